/* rtl/core/mbpg_pkg.sv */
// Package for the metaball pixel generator core: widths, defaults, request
// codes, sequencer states and the blob bank command struct.
// No dependencies.
package mbpg_pkg;

  // Register and payload widths
  localparam int unsigned STRENGTH_W = 16;
  localparam int unsigned POS_W      = 9;   // blob position, two's complement
  localparam int unsigned PIX_W      = 7;   // pixel row / column
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned LDIDX_W    = 2;   // blob_index field
  localparam int unsigned START_W    = 8;
  localparam int unsigned CH_W       = 8;   // colour channel
  localparam int unsigned DIST_W     = 9;   // |blob - pixel| on one axis
  localparam int unsigned SQ_W       = 2 * DIST_W;
  localparam int unsigned DEN_W      = SQ_W + 1;
  localparam int unsigned CMP_W      = 12;  // signed compare against frame size

  localparam logic [STRENGTH_W-1:0] STRENGTH_RESET = 16'd6000;
  localparam logic [CH_W-1:0]       CH_MAX         = 8'd255;

  // Defaults for the top level parameters
  localparam int unsigned BLOB_CNT_DEF     = 4;
  localparam int unsigned FRAME_WIDTH_DEF  = 128;
  localparam int unsigned FRAME_HEIGHT_DEF = 128;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADVANCE = 2'd0,
    REQ_RENDER  = 2'd1,
    REQ_LOAD    = 2'd2
  } req_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADV,
    ST_LOAD,
    ST_SQX,
    ST_SQY,
    ST_DIVS,
    ST_DIVW,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    BANK_HOLD,
    BANK_ADV,
    BANK_LOAD
  } bank_op_e;

  typedef struct packed {
    bank_op_e          op;
    logic [POS_W-1:0]  ld_x;
    logic [POS_W-1:0]  ld_y;
  } bank_cmd_t;

endpackage

/* rtl/core/mbpg_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on mbpg_pkg.
module mbpg_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [mbpg_pkg::STRENGTH_W-1:0]   num_i,
  input  logic [mbpg_pkg::DEN_W-1:0]        den_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic [mbpg_pkg::STRENGTH_W-1:0]   quot_o
);
  import mbpg_pkg::*;

  localparam int unsigned CNT_W = $clog2(STRENGTH_W + 1);

  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  done_q, done_d;
  logic [DEN_W-1:0]      rem_q, rem_d;
  logic [STRENGTH_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0]      den_q, den_d;
  logic [DEN_W:0]        shifted;
  logic                  fits;

  assign shifted = {rem_q, quo_q[STRENGTH_W-1]};
  assign fits    = shifted >= {1'b0, den_q};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      cnt_d = CNT_W'(STRENGTH_W);
      rem_d = '0;
      quo_d = num_i;
      den_d = den_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
      if (fits) begin
        rem_d = DEN_W'(shifted - {1'b0, den_q});
      end else begin
        rem_d = shifted[DEN_W-1:0];
      end
      quo_d = {quo_q[STRENGTH_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign busy_o = cnt_q != '0;
  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

/* rtl/core/mbpg_blob_bank.sv */
// Blob state: positions and step directions, one blob advanced or loaded
// per cycle at the selected index. Depends on mbpg_pkg.
module mbpg_blob_bank #(
  parameter int unsigned BLOB_CNT     = mbpg_pkg::BLOB_CNT_DEF,
  parameter int unsigned FRAME_WIDTH  = mbpg_pkg::FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT = mbpg_pkg::FRAME_HEIGHT_DEF,
  parameter int unsigned IDX_W        = (BLOB_CNT > 1) ? $clog2(BLOB_CNT) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mbpg_pkg::bank_cmd_t           cmd_i,
  input  logic [IDX_W-1:0]              idx_i,
  output logic [mbpg_pkg::POS_W-1:0]    pos_x_o,
  output logic [mbpg_pkg::POS_W-1:0]    pos_y_o
);
  import mbpg_pkg::*;

  logic [POS_W-1:0] pos_x_q [BLOB_CNT];
  logic [POS_W-1:0] pos_y_q [BLOB_CNT];
  logic             neg_x_q [BLOB_CNT];
  logic             neg_y_q [BLOB_CNT];

  logic [POS_W-1:0] nx, ny;
  logic             nneg_x, nneg_y;

  // step then bounce on the new position
  always_comb begin
    nx     = neg_x_q[idx_i] ? pos_x_q[idx_i] - POS_W'(1) : pos_x_q[idx_i] + POS_W'(1);
    ny     = neg_y_q[idx_i] ? pos_y_q[idx_i] - POS_W'(1) : pos_y_q[idx_i] + POS_W'(1);
    nneg_x = neg_x_q[idx_i];
    nneg_y = neg_y_q[idx_i];
    if (nx[POS_W-1]) begin
      nneg_x = 1'b0;
    end
    if ($signed({{(CMP_W-POS_W){nx[POS_W-1]}}, nx}) > $signed(CMP_W'(FRAME_WIDTH))) begin
      nneg_x = 1'b1;
    end
    if (ny[POS_W-1]) begin
      nneg_y = 1'b0;
    end
    if ($signed({{(CMP_W-POS_W){ny[POS_W-1]}}, ny}) > $signed(CMP_W'(FRAME_HEIGHT))) begin
      nneg_y = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BLOB_CNT; i++) begin
        pos_x_q[i] <= '0;
        pos_y_q[i] <= '0;
        neg_x_q[i] <= 1'b0;
        neg_y_q[i] <= 1'b0;
      end
    end else begin
      case (cmd_i.op)
        BANK_ADV: begin
          pos_x_q[idx_i] <= nx;
          pos_y_q[idx_i] <= ny;
          neg_x_q[idx_i] <= nneg_x;
          neg_y_q[idx_i] <= nneg_y;
        end
        BANK_LOAD: begin
          pos_x_q[idx_i] <= cmd_i.ld_x;
          pos_y_q[idx_i] <= cmd_i.ld_y;
          neg_x_q[idx_i] <= 1'b0;
          neg_y_q[idx_i] <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign pos_x_o = pos_x_q[idx_i];
  assign pos_y_o = pos_y_q[idx_i];

endmodule

/* rtl/core/metaball_pixel_generator_core.sv */
// Metaball pixel generator core: sequencer, shared squarer, shared divider.
// Render: per blob SQX, SQY, DIVS, then DIVW until the divider's quotient lands;
// after the last blob, FIN presents the pixel; a held pixel stalls FIN.
// Advance: one blob per cycle. Load: LOAD writes the indexed blob if in range.
// One transaction in flight; s_axis_tready_o is high only while idle.
// Async active-low reset: blobs at 0 moving +1, strength 6000, no output.
// Depends on mbpg_pkg, mbpg_blob_bank, mbpg_div.
module metaball_pixel_generator_core #(
  parameter int unsigned BLOB_CNT     = mbpg_pkg::BLOB_CNT_DEF,
  parameter int unsigned FRAME_WIDTH  = mbpg_pkg::FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT = mbpg_pkg::FRAME_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: blob_strength
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: pixel_x[6:0], pixel_y[13:7], blob_index[15:14], start_x[23:16],
  //        start_y[31:24]
  input  logic [31:0] s_axis_tdata_i,
  // tuser: req_type[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  // pixel stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: red[7:0], green[15:8], blue[23:16]
  output logic [23:0] m_axis_tdata_o
);
  import mbpg_pkg::*;

  localparam int unsigned IDX_W = (BLOB_CNT > 1) ? $clog2(BLOB_CNT) : 1;
  localparam int unsigned ACC_W = STRENGTH_W + $clog2(BLOB_CNT + 1) + 1;
  localparam int unsigned BI_W  = 5;  // holds BLOB_CNT up to 16

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [STRENGTH_W-1:0] strength_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strength_q <= STRENGTH_RESET;
    end else if (cfg_we_i) begin
      strength_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Input fields
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0]   in_px, in_py;
  logic [LDIDX_W-1:0] in_bi;
  logic [START_W-1:0] in_sx, in_sy;
  logic [BI_W-1:0]    in_bi_ext;
  logic               s_fire;

  assign in_px     = s_axis_tdata_i[6:0];
  assign in_py     = s_axis_tdata_i[13:7];
  assign in_bi     = s_axis_tdata_i[15:14];
  assign in_sx     = s_axis_tdata_i[23:16];
  assign in_sy     = s_axis_tdata_i[31:24];
  assign in_bi_ext = {{(BI_W-LDIDX_W){1'b0}}, in_bi};
  assign s_fire    = s_axis_tvalid_i && s_axis_tready_o;

  // ---------------------------------------------------------------------------
  // Sequencer state and datapath registers
  // ---------------------------------------------------------------------------
  state_e             state_q, state_d;
  logic [IDX_W-1:0]   cnt_q;
  logic [PIX_W-1:0]   px_q, py_q;
  logic [IDX_W-1:0]   ld_idx_q;
  logic               ld_ok_q;
  logic [START_W-1:0] sx_q, sy_q;
  logic [SQ_W-1:0]    sq_q;
  logic [DEN_W-1:0]   den_q;
  logic [ACC_W-1:0]   acc_q;
  logic               out_valid_q;
  logic [CH_W-1:0]    red_q, green_q, blue_q;

  logic               last_blob;
  logic               out_free;

  // shared units
  bank_cmd_t             bank_cmd;
  logic [IDX_W-1:0]      bank_idx;
  logic [POS_W-1:0]      blob_x, blob_y;
  logic                  div_start, div_busy, div_done;
  logic [STRENGTH_W-1:0] div_quot;

  assign last_blob = cnt_q == IDX_W'(BLOB_CNT - 1);
  assign out_free  = !out_valid_q || m_axis_tready_i;

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          case (s_axis_tuser_i)
            REQ_ADVANCE: state_d = ST_ADV;
            REQ_RENDER:  state_d = ST_SQX;
            REQ_LOAD:    state_d = ST_LOAD;
            default:     state_d = ST_IDLE;  // unused code: no effect
          endcase
        end
      end
      ST_ADV:  state_d = last_blob ? ST_IDLE : ST_ADV;
      ST_LOAD: state_d = ST_IDLE;
      ST_SQX:  state_d = ST_SQY;
      ST_SQY:  state_d = ST_DIVS;
      ST_DIVS: state_d = ST_DIVW;
      ST_DIVW: begin
        if (div_done) begin
          state_d = last_blob ? ST_FIN : ST_SQX;
        end
      end
      ST_FIN:  state_d = out_free ? ST_IDLE : ST_FIN;
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    bank_cmd.op   = BANK_HOLD;
    bank_cmd.ld_x = {{(POS_W-START_W){1'b0}}, sx_q};
    bank_cmd.ld_y = {{(POS_W-START_W){1'b0}}, sy_q};
    bank_idx      = cnt_q;
    div_start     = 1'b0;
    case (state_q)
      ST_ADV: bank_cmd.op = BANK_ADV;
      ST_LOAD: begin
        bank_idx = ld_idx_q;
        if (ld_ok_q) begin
          bank_cmd.op = BANK_LOAD;
        end
      end
      ST_DIVS: div_start = 1'b1;
      default: begin
      end
    endcase
  end

  assign s_axis_tready_o = state_q == ST_IDLE;

  // ---------------------------------------------------------------------------
  // Shared squarer: |dx| in SQX, |dy| in SQY
  // ---------------------------------------------------------------------------
  logic signed [POS_W:0] diff_x, diff_y, diff_sel;
  logic [DIST_W-1:0]     mul_a;
  logic [SQ_W-1:0]       prod;

  assign diff_x   = $signed({blob_x[POS_W-1], blob_x}) -
                    $signed({{(POS_W+1-PIX_W){1'b0}}, px_q});
  assign diff_y   = $signed({blob_y[POS_W-1], blob_y}) -
                    $signed({{(POS_W+1-PIX_W){1'b0}}, py_q});
  assign diff_sel = (state_q == ST_SQX) ? diff_x : diff_y;

  always_comb begin
    if (diff_sel[POS_W]) begin
      mul_a = DIST_W'(-diff_sel);
    end else begin
      mul_a = DIST_W'(diff_sel);
    end
  end

  assign prod = {{(SQ_W-DIST_W){1'b0}}, mul_a} * {{(SQ_W-DIST_W){1'b0}}, mul_a};

  // ---------------------------------------------------------------------------
  // Colour with saturation
  // ---------------------------------------------------------------------------
  logic [ACC_W-1:0] sum_r, sum_g, sum_b;

  assign sum_r = acc_q + ACC_W'(py_q);
  assign sum_g = acc_q + ACC_W'(px_q);
  assign sum_b = acc_q + ACC_W'(px_q) + ACC_W'(py_q);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (s_fire) begin
        cnt_q <= '0;
      end else if ((state_q == ST_ADV || (state_q == ST_DIVW && div_done)) && !last_blob) begin
        cnt_q <= cnt_q + IDX_W'(1);
      end
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      px_q     <= in_px;
      py_q     <= in_py;
      sx_q     <= in_sx;
      sy_q     <= in_sy;
      ld_idx_q <= in_bi_ext[IDX_W-1:0];
      ld_ok_q  <= in_bi_ext < BI_W'(BLOB_CNT);
      acc_q    <= ACC_W'(1);
    end
    if (state_q == ST_SQX) begin
      sq_q <= prod;
    end
    if (state_q == ST_SQY) begin
      den_q <= DEN_W'(sq_q) + DEN_W'(prod) + DEN_W'(1);
    end
    if (state_q == ST_DIVW && div_done) begin
      acc_q <= acc_q + ACC_W'(div_quot);
    end
    if (state_q == ST_FIN && out_free) begin
      red_q   <= (sum_r > ACC_W'(CH_MAX)) ? CH_MAX : sum_r[CH_W-1:0];
      green_q <= (sum_g > ACC_W'(CH_MAX)) ? CH_MAX : sum_g[CH_W-1:0];
      blue_q  <= (sum_b > ACC_W'(CH_MAX)) ? CH_MAX : sum_b[CH_W-1:0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {blue_q, green_q, red_q};

  // ---------------------------------------------------------------------------
  // Sub-units
  // ---------------------------------------------------------------------------
  mbpg_blob_bank #(
    .BLOB_CNT     (BLOB_CNT),
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .IDX_W        (IDX_W)
  ) u_bank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (bank_cmd),
    .idx_i   (bank_idx),
    .pos_x_o (blob_x),
    .pos_y_o (blob_y)
  );

  mbpg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (strength_q),
    .den_i   (den_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // divider is only kicked when it has finished the previous quotient
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // a quotient only ever lands while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIVW)
    else $error("divider result outside wait state");

  // a new pixel is only presented after the final colour step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q) == ST_FIN)
    else $error("pixel output without render completion");

  // blob counter stays inside the bank
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= IDX_W'(BLOB_CNT - 1))
    else $error("blob counter out of range");

endmodule
